@@ src/sec_pkg.sv @@
// Shared types, codes and constants of the slip event conflict check.
// No dependencies; every file of the block but sec_ifs.sv imports this package.
package sec_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  localparam logic [62:0] THRESH_RESET = 63'd72057594037928;

  localparam logic [1:0] K_ZIPPER = 2'd0;
  localparam logic [1:0] K_NORMAL = 2'd1;

  localparam logic [1:0] V_COMMIT  = 2'd0;
  localparam logic [1:0] V_REJECT  = 2'd1;
  localparam logic [1:0] V_FULL    = 2'd2;
  localparam logic [1:0] V_CLEARED = 2'd3;

  typedef struct packed {
    logic        normal;
    logic [23:0] node;
    logic [23:0] nbr_a;
    logic [23:0] nbr_b;
    logic [15:0] pz;
    logic [15:0] py;
    logic [15:0] px;
  } entry_t;

  typedef struct packed {
    logic       load_evt;
    logic       clear_tab;
    logic       issue;
    logic       commit;
    logic       out_load;
    logic [1:0] verdict;
  } cmd_t;

  typedef struct packed {
    logic is_clear;
    logic is_full;
    logic empty;
    logic scan_last;
    logic busy;
    logic hit;
    logic out_free;
  } sts_t;

endpackage

@@ src/sec_ifs.sv @@
// Valid/ready channel interfaces of the slip event conflict check:
// event input, verdict output and threshold write. No dependencies.
interface sec_evt_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  kind;
  logic        [23:0] node_id;
  logic        [23:0] nbr_a_id;
  logic        [23:0] nbr_b_id;
  logic signed [15:0] plane_x;
  logic signed [15:0] plane_y;
  logic signed [15:0] plane_z;

  modport source (output valid, kind, node_id, nbr_a_id, nbr_b_id, plane_x, plane_y, plane_z,
                  input ready);
  modport sink (input valid, kind, node_id, nbr_a_id, nbr_b_id, plane_x, plane_y, plane_z,
                output ready);
endinterface

interface sec_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, verdict, input ready);
  modport sink (input valid, verdict, output ready);
endinterface

interface sec_cfg_if;
  logic        valid;
  logic        ready;
  logic [62:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ src/slip_event_conflict_check.sv @@
// Slip event conflict check. An event passes accept, decide, scan, drain and finish; the
// scan covers the n committed entries one by one: the entry memory has one read port, so
// the scan reads one entry a cycle, and each read then passes a five-stage share and
// cross-product pipeline before the verdict is known. A clear item, and any event while
// the table is full, skips scan and drain; an empty table skips the scan. The next item is
// accepted while a verdict still waits in the output register. The threshold may be
// written in any cycle; it must be written only while no item is in progress.
module slip_event_conflict_check #(
  parameter int TABLE_DEPTH = sec_pkg::TABLE_DEPTH_DEF
) (
  input logic      clk,
  input logic      rst,
  sec_evt_if.sink  evt,
  sec_res_if.source res,
  sec_cfg_if.sink  cfg
);
  import sec_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic evt_ready;
  logic res_valid;
  logic [1:0] res_verdict;

  assign evt.ready   = evt_ready;
  assign cfg.ready   = 1'b1;
  assign res.valid   = res_valid;
  assign res.verdict = res_verdict;

  sec_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt.valid),
    .evt_ready (evt_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sec_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .kind        (evt.kind),
    .node_id     (evt.node_id),
    .nbr_a_id    (evt.nbr_a_id),
    .nbr_b_id    (evt.nbr_b_id),
    .plane_x     (evt.plane_x),
    .plane_y     (evt.plane_y),
    .plane_z     (evt.plane_z),
    .cfg_we      (cfg.valid),
    .cfg_data    (cfg.data),
    .res_valid   (res_valid),
    .res_ready   (res.ready),
    .res_verdict (res_verdict)
  );

endmodule

@@ src/sec_ctrl.sv @@
// Sequencer of the slip event conflict check: accept, decide, scan, drain, finish.
// Depends on sec_pkg; drives sec_dpath through cmd_t and reads sts_t.
module sec_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          evt_valid,
  output logic          evt_ready,
  input  sec_pkg::sts_t sts,
  output sec_pkg::cmd_t cmd
);
  import sec_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state, state_next;
  logic [1:0] verdict, verdict_next;

  assign evt_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    verdict_next = verdict;
    cmd          = '0;
    cmd.verdict  = verdict;
    case (state)
      S_IDLE: begin
        if (evt_valid) begin
          cmd.load_evt = 1'b1;
          state_next   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.is_clear) begin
          cmd.clear_tab = 1'b1;
          verdict_next  = V_CLEARED;
          state_next    = S_FINISH;
        end else if (sts.is_full) begin
          verdict_next = V_FULL;
          state_next   = S_FINISH;
        end else if (sts.empty) begin
          state_next = S_DRAIN;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts.busy) begin
          cmd.commit   = !sts.hit;
          verdict_next = sts.hit ? V_REJECT : V_COMMIT;
          state_next   = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      verdict <= V_COMMIT;
    end else begin
      state   <= state_next;
      verdict <= verdict_next;
    end
  end

endmodule

@@ src/sec_dpath.sv @@
// Datapath of the slip event conflict check: entry memory, event register,
// sharing compare, cross-product pipeline, threshold and verdict registers. Uses sec_pkg.
module sec_dpath #(
  parameter int TABLE_DEPTH = sec_pkg::TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  sec_pkg::cmd_t      cmd,
  output sec_pkg::sts_t      sts,
  input  logic        [1:0]  kind,
  input  logic        [23:0] node_id,
  input  logic        [23:0] nbr_a_id,
  input  logic        [23:0] nbr_b_id,
  input  logic signed [15:0] plane_x,
  input  logic signed [15:0] plane_y,
  input  logic signed [15:0] plane_z,
  input  logic               cfg_we,
  input  logic        [62:0] cfg_data,
  output logic               res_valid,
  input  logic               res_ready,
  output logic        [1:0]  res_verdict
);
  import sec_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  entry_t        mem [TABLE_DEPTH];
  entry_t        cur;
  logic [1:0]    cur_kind;
  entry_t        rd_q;
  logic [62:0]   thr;
  logic [CW-1:0] used;
  logic [CW-1:0] scan;

  logic v1, v2, v3, v4, v5;
  logic sh2, sh3, sh4, sh5;
  logic hit;
  logic share_c;

  logic signed [15:0] ax, ay, az, bx, by, bz;
  logic signed [31:0] p0, p1, p2, p3, p4, p5;
  logic signed [32:0] c0, c1, c2;
  logic signed [65:0] sqf0, sqf1, sqf2;
  logic        [63:0] sq0, sq1, sq2;
  logic        [63:0] sum;

  assign sts.is_clear  = cur_kind[1];
  assign sts.is_full   = (used == CW'(TABLE_DEPTH));
  assign sts.empty     = (used == '0);
  assign sts.scan_last = ((scan + CW'(1)) == used);
  assign sts.busy      = v1 | v2 | v3 | v4 | v5;
  assign sts.hit       = hit;
  assign sts.out_free  = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (cmd.load_evt) begin
      cur_kind   <= kind;
      cur.normal <= (kind == K_NORMAL);
      cur.node   <= node_id;
      cur.nbr_a  <= nbr_a_id;
      cur.nbr_b  <= nbr_b_id;
      cur.px     <= plane_x;
      cur.py     <= plane_y;
      cur.pz     <= plane_z;
    end
    if (cmd.commit) begin
      mem[used[AW-1:0]] <= cur;
    end
    if (cmd.issue) begin
      rd_q <= mem[scan[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr  <= THRESH_RESET;
      used <= '0;
      scan <= '0;
    end else begin
      if (cfg_we) begin
        thr <= cfg_data;
      end
      if (cmd.clear_tab) begin
        used <= '0;
      end else if (cmd.commit) begin
        used <= used + CW'(1);
      end
      if (cmd.load_evt) begin
        scan <= '0;
      end else if (cmd.issue) begin
        scan <= scan + CW'(1);
      end
    end
  end

  always_comb begin
    if (!cur.normal) begin
      share_c = !rd_q.normal &&
                (cur.node == rd_q.nbr_a || cur.nbr_a == rd_q.node ||
                 cur.nbr_a == rd_q.nbr_a);
    end else if (!rd_q.normal) begin
      share_c = cur.node == rd_q.nbr_a || cur.nbr_a == rd_q.node ||
                cur.nbr_a == rd_q.nbr_a || cur.nbr_b == rd_q.node ||
                cur.nbr_b == rd_q.nbr_a;
    end else begin
      share_c = cur.node == rd_q.nbr_a || cur.node == rd_q.nbr_b ||
                cur.nbr_a == rd_q.nbr_a || cur.nbr_a == rd_q.node ||
                cur.nbr_a == rd_q.nbr_b || cur.nbr_b == rd_q.nbr_a ||
                cur.nbr_b == rd_q.node || cur.nbr_b == rd_q.nbr_b;
    end
  end

  assign ax = $signed(rd_q.px);
  assign ay = $signed(rd_q.py);
  assign az = $signed(rd_q.pz);
  assign bx = $signed(cur.px);
  assign by = $signed(cur.py);
  assign bz = $signed(cur.pz);

  assign sqf0 = c0 * c0;
  assign sqf1 = c1 * c1;
  assign sqf2 = c2 * c2;

  always_ff @(posedge clk) begin
    p0  <= ay * bz;
    p1  <= az * by;
    p2  <= az * bx;
    p3  <= ax * bz;
    p4  <= ax * by;
    p5  <= ay * bx;
    sh2 <= share_c;
    c0  <= {p0[31], p0} - {p1[31], p1};
    c1  <= {p2[31], p2} - {p3[31], p3};
    c2  <= {p4[31], p4} - {p5[31], p5};
    sh3 <= sh2;
    sq0 <= sqf0[63:0];
    sq1 <= sqf1[63:0];
    sq2 <= sqf2[63:0];
    sh4 <= sh3;
    sum <= sq0 + sq1 + sq2;
    sh5 <= sh4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
      v5  <= 1'b0;
      hit <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      if (cmd.load_evt) begin
        hit <= 1'b0;
      end else if (v5 && sh5 && (sum > {1'b0, thr})) begin
        hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_verdict <= cmd.verdict;
    end
  end

endmodule

@@ src/sec_check.sv @@
// Port-level assertions of the slip event conflict check, bound to the top level.
// Depends on sec_pkg for the verdict codes.
module sec_check (
  input logic       clk,
  input logic       rst,
  input logic       evt_valid,
  input logic       evt_ready,
  input logic [1:0] evt_kind,
  input logic       res_valid,
  input logic       res_ready,
  input logic [1:0] res_verdict
);
  import sec_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_verdict)))
    else $error("verdict changed or dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (evt_valid && evt_ready) |=> !evt_ready)
    else $error("second event taken while one is in progress");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (evt_valid && evt_ready && !res_valid) |=> !res_valid)
    else $error("verdict appeared in the cycle after the transfer");

  a_clear_verdict: assert property (@(posedge clk) disable iff (rst)
    (evt_valid && evt_ready && evt_kind[1] && !res_valid)
      |-> ##3 (res_valid && res_verdict == V_CLEARED))
    else $error("clear item did not answer cleared in time");

endmodule

bind slip_event_conflict_check sec_check u_sec_check (
  .clk         (clk),
  .rst         (rst),
  .evt_valid   (evt.valid),
  .evt_ready   (evt.ready),
  .evt_kind    (evt.kind),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .res_verdict (res.verdict)
);
